[rtl/rfa_pkg.sv]
package rfa_pkg;

  // Field widths
  localparam int X_W   = 16;
  localparam int SUM_W = 28;
  localparam int SQ_W  = 17;
  localparam int TBL_W = 17;

  // Cosine table size (index bits)
  localparam int COS_BITS = 10;
  localparam int TBL_SIZE = 1 << COS_BITS;

  // Input clamp and accumulator full scale
  localparam logic signed [X_W-1:0] X_LIMIT = 16'sd20972;
  localparam logic [SUM_W-1:0]      SUM_MAX = {SUM_W{1'b1}};

  // Q30 constants for the table build
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint          ONE_Q30 = 64'sd1073741824;

  typedef logic [TBL_W-1:0] tbl_entry_t;
  typedef tbl_entry_t tbl_t [TBL_SIZE];

  // Term stage to accumulator
  typedef struct packed {
    logic            valid;
    logic            last;
    logic [SQ_W-1:0] sq;
    tbl_entry_t      tbl;
  } rfa_term_t;

  // Quotient by restoring long division
  function automatic longint unsigned quo_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // cos(a) for a in the first quarter wave, Q30 in and out
  function automatic longint cos_q30(input longint unsigned a);
    longint unsigned a2;
    longint unsigned t;
    longint          s;
    a2 = (a * a) >> 30;
    t  = longint'(ONE_Q30);
    s  = ONE_Q30;
    for (int n = 1; n <= 14; n++) begin
      t = (t * a2) >> 30;
      t = quo_u64(t, longint'((2 * n - 1) * (2 * n)));
      if (n[0]) begin
        s = s - longint'(t);
      end else begin
        s = s + longint'(t);
      end
    end
    return s;
  endfunction

  // Entry k holds round(40960 * (1 - cos(2 pi k / TBL_SIZE)))
  function automatic tbl_t build_tbl();
    tbl_t            tbl;
    longint unsigned q;
    longint unsigned quad;
    longint unsigned r;
    longint unsigned rr;
    longint unsigned ang;
    longint          c;
    longint          d;
    q = longint'(TBL_SIZE) >> 2;
    for (int k = 0; k < TBL_SIZE; k++) begin
      quad = (longint'(k) >> (COS_BITS - 2)) & 64'd3;
      r    = longint'(k) & (q - 64'd1);
      rr   = quad[0] ? (q - r) : r;
      ang  = (64'd2 * PI_Q30 * rr) >> COS_BITS;
      c    = cos_q30(ang);
      if (quad == 64'd1 || quad == 64'd2) begin
        c = -c;
      end
      d = ONE_Q30 - c;
      if (d < 0) begin
        d = 0;
      end
      tbl[k] = tbl_entry_t'((64'd40960 * longint'(d) + (64'd1 << 29)) >> 30);
    end
    return tbl;
  endfunction

  localparam tbl_t TERM_TBL = build_tbl();

endpackage

[rtl/rfa_ifs.sv]
// Input channel: one decision variable per transaction
interface rfa_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [rfa_pkg::X_W-1:0]      x_value;
  logic                                last_var;

  modport source (output valid, x_value, last_var, input ready);
  modport sink   (input valid, x_value, last_var, output ready);
endinterface

// Output channel: one fitness total per solution
interface rfa_out_if;
  logic                       valid;
  logic                       ready;
  logic [rfa_pkg::SUM_W-1:0]  fitness;
  logic                       saturated;

  modport source (output valid, fitness, saturated, input ready);
  modport sink   (input valid, fitness, saturated, output ready);
endinterface

[rtl/rfa_term.sv]
module rfa_term (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  logic                            take,
  input  logic signed [rfa_pkg::X_W-1:0]  x_value,
  input  logic                            last_var,
  output rfa_pkg::rfa_term_t              term
);

  logic signed [rfa_pkg::X_W-1:0]   xc;
  logic [rfa_pkg::X_W-1:0]          xneg;
  logic [rfa_pkg::X_W-2:0]          ax;
  logic [2*(rfa_pkg::X_W-1)-1:0]    sq_full;
  logic [rfa_pkg::COS_BITS+11:0]    idx_sum;
  logic [rfa_pkg::COS_BITS-1:0]     idx;

  // Clamp to +/-5.12 and take the magnitude
  always_comb begin
    if (x_value > rfa_pkg::X_LIMIT) begin
      xc = rfa_pkg::X_LIMIT;
    end else if (x_value < -rfa_pkg::X_LIMIT) begin
      xc = -rfa_pkg::X_LIMIT;
    end else begin
      xc = x_value;
    end
    xneg = -xc;
    ax   = xc[rfa_pkg::X_W-1] ? xneg[rfa_pkg::X_W-2:0] : xc[rfa_pkg::X_W-2:0];
  end

  // Square rounded back to Q.12, half up
  assign sq_full = ax * ax + (2*(rfa_pkg::X_W-1))'(2048);

  // Table index from the fraction, rounded to COS_BITS
  assign idx_sum = {xc[11:0], {rfa_pkg::COS_BITS{1'b0}}}
                   + (rfa_pkg::COS_BITS+12)'(2048);
  assign idx     = idx_sum[rfa_pkg::COS_BITS+11:12];

  // Stage valid and payload, table read registered
  always_ff @(posedge clk) begin
    if (advance) begin
      term.last <= last_var;
      term.sq   <= sq_full[rfa_pkg::SQ_W+11:12];
      term.tbl  <= rfa_pkg::TERM_TBL[idx];
    end
    if (rst) begin
      term.valid <= 1'b0;
    end else if (advance) begin
      term.valid <= take;
    end
  end

endmodule

[rtl/rfa_accum.sv]
module rfa_accum (
  input  logic                       clk,
  input  logic                       rst,
  input  rfa_pkg::rfa_term_t         term,
  output logic                       hold,
  rfa_out_if.source                  res
);

  logic [rfa_pkg::SUM_W-1:0] running_sum;
  logic                      overflow_seen;
  logic [rfa_pkg::SUM_W:0]   sum_wide;
  logic                      clip;
  logic [rfa_pkg::SUM_W-1:0] sum_next;
  logic                      overflow_next;
  logic                      consume;

  // A last item stalls only while the result register is still occupied
  assign hold    = term.valid && term.last && res.valid && !res.ready;
  assign consume = term.valid && !hold;

  // Add the term and saturate at full scale
  assign sum_wide      = {1'b0, running_sum} + (rfa_pkg::SUM_W+1)'(term.sq)
                         + (rfa_pkg::SUM_W+1)'(term.tbl);
  assign clip          = sum_wide[rfa_pkg::SUM_W];
  assign sum_next      = clip ? rfa_pkg::SUM_MAX : sum_wide[rfa_pkg::SUM_W-1:0];
  assign overflow_next = overflow_seen | clip;

  // Accumulator and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      overflow_seen <= 1'b0;
      res.valid     <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      if (consume) begin
        if (term.last) begin
          res.valid     <= 1'b1;
          running_sum   <= '0;
          overflow_seen <= 1'b0;
        end else begin
          running_sum   <= sum_next;
          overflow_seen <= overflow_next;
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (consume && term.last) begin
      res.fitness   <= sum_next;
      res.saturated <= overflow_next;
    end
  end

endmodule

[rtl/rastrigin_fitness_accumulator_core.sv]
// Channel   Dir  Payload                               Transaction
// in_ch     in   x_value[15:0] signed, last_var        valid & ready
// out_ch    out  fitness[27:0], saturated              valid & ready
//
// One variable is taken per cycle while in_ch.ready is high; stage two registers results.
// Stage one holds the square and the registered cosine-table read; stage two accumulates.
// Reset (rst, synchronous) clears the running sum, the overflow flag and both valids.
// in_ch.ready drops only while a last variable waits on an occupied, unread result.

module rastrigin_fitness_accumulator_core (
  input  logic      clk,
  input  logic      rst,
  rfa_in_if.sink    in_ch,
  rfa_out_if.source out_ch
);

  rfa_pkg::rfa_term_t term;
  logic               hold;

  assign in_ch.ready = !hold;

  // Clamp, square and table read
  rfa_term u_term (
    .clk      (clk),
    .rst      (rst),
    .advance  (!hold),
    .take     (in_ch.valid),
    .x_value  (in_ch.x_value),
    .last_var (in_ch.last_var),
    .term     (term)
  );

  // Running sum and result register
  rfa_accum u_accum (
    .clk  (clk),
    .rst  (rst),
    .term (term),
    .hold (hold),
    .res  (out_ch)
  );

  // A saturated total always reads full scale
  a_sat_full: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.saturated |-> out_ch.fitness == rfa_pkg::SUM_MAX)
    else $error("saturated result below full scale");

  // Input back-pressure only comes from a blocked result
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled without output back-pressure");

  // Reset leaves no result pending
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule
